// ----- sv/csitr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csitr_pkg
// Shared types and codes for the control/status and interval timer registers.
// ----------------------------------------------------------------------------
package csitr_pkg;

  // Request word: one bus access or a clock tick
  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] offset;
    logic       byte_access;
    logic [7:0] wdata;
  } in_word_t;

  // Response word
  typedef struct packed {
    logic [15:0] rdata;
    logic [15:0] status_word;
    logic        reset_request;
    logic        reload_pulse;
  } out_word_t;

  // Per-counter strobes for the current word
  typedef struct packed {
    logic rd;      // count read at this counter's offset
    logic wr;      // divider load at this counter's offset
    logic ctl;     // control write selecting this counter
    logic reload;  // timer inhibit cleared
  } cnt_ctrl_t;

  // Access kinds
  localparam logic [2:0] MODE_ST_RD  = 3'd0;
  localparam logic [2:0] MODE_ST_WR  = 3'd1;
  localparam logic [2:0] MODE_TMR_RD = 3'd2;
  localparam logic [2:0] MODE_TMR_WR = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  // Highest number of counters the address map holds
  localparam int MaxCounters = 3;

  // Status read offsets
  localparam logic [5:0] OFF_ST_WORD = 6'h02;
  localparam logic [5:0] OFF_ST_LOW  = 6'h03;

  // Status write offsets
  localparam logic [5:0] OFF_TIMO_CLR = 6'h03;
  localparam logic [5:0] OFF_PARE_CLR = 6'h07;
  localparam logic [5:0] OFF_SYS_RST  = 6'h0b;
  localparam logic [5:0] OFF_ALGN_CLR = 6'h0f;
  localparam logic [5:0] OFF_LED_SET  = 6'h13;
  localparam logic [5:0] OFF_LED_CLR  = 6'h17;
  localparam logic [5:0] OFF_FLOP_SET = 6'h1b;
  localparam logic [5:0] OFF_FLOP_CLR = 6'h1f;
  localparam logic [5:0] OFF_ITIM_SET = 6'h23;
  localparam logic [5:0] OFF_ITIM_CLR = 6'h27;
  localparam logic [5:0] OFF_IFLT_SET = 6'h2b;
  localparam logic [5:0] OFF_IFLT_CLR = 6'h2f;
  localparam logic [5:0] OFF_PIR9_SET = 6'h33;
  localparam logic [5:0] OFF_PIR9_CLR = 6'h37;
  localparam logic [5:0] OFF_PIR8_SET = 6'h3b;
  localparam logic [5:0] OFF_PIR8_CLR = 6'h3f;

  // Timer offsets (counters sit at 4*n+3)
  localparam logic [5:0] OFF_TMR_CTL   = 6'h0f;
  localparam logic [5:0] OFF_TMR_LATCH = 6'h13;

  // Status bit positions
  localparam int B_PIR9 = 4;
  localparam int B_PIR8 = 5;
  localparam int B_CLK  = 6;
  localparam int B_IFLT = 7;
  localparam int B_ITIM = 8;
  localparam int B_FLOP = 9;
  localparam int B_LED  = 11;
  localparam int B_ALGN = 12;
  localparam int B_PARE = 14;
  localparam int B_TIMO = 15;

  // Counter byte modes (mode bits 5:4)
  localparam logic [1:0] BM_NONE = 2'd0;
  localparam logic [1:0] BM_LOW  = 2'd1;
  localparam logic [1:0] BM_HIGH = 2'd2;
  localparam logic [1:0] BM_ALT  = 2'd3;

endpackage

// ----- sv/csitr_status.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csitr_status
// Control/status word: status reads, set/clear writes, clock tick, latch clear.
// ----------------------------------------------------------------------------
module csitr_status (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  csitr_pkg::in_word_t req,
  input  logic                cnt1_en,
  output logic [15:0]         status_word,
  output logic [15:0]         rdata,
  output logic                reset_request
);
  import csitr_pkg::*;

  logic [15:0] st;
  logic [15:0] st_next;

  // Next status word and read data for the current word
  always_comb begin
    st_next       = st;
    rdata         = '0;
    reset_request = 1'b0;
    case (req.mode)
      MODE_ST_RD: begin
        if (req.offset == OFF_ST_WORD) begin
          rdata = req.byte_access ? {8'h00, st[15:8]} : st;
        end else if (req.offset == OFF_ST_LOW) begin
          rdata = {8'h00, st[7:0]};
        end
      end
      MODE_ST_WR: begin
        unique case (req.offset)
          OFF_TIMO_CLR: st_next[B_TIMO] = 1'b0;
          OFF_PARE_CLR: st_next[B_PARE] = 1'b0;
          OFF_SYS_RST:  reset_request   = 1'b1;
          OFF_ALGN_CLR: st_next[B_ALGN] = 1'b0;
          OFF_LED_SET:  st_next[B_LED]  = 1'b1;
          OFF_LED_CLR:  st_next[B_LED]  = 1'b0;
          OFF_FLOP_SET: st_next[B_FLOP] = 1'b1;
          OFF_FLOP_CLR: st_next[B_FLOP] = 1'b0;
          OFF_ITIM_SET: st_next[B_ITIM] = 1'b1;
          OFF_ITIM_CLR: st_next[B_ITIM] = 1'b0;
          OFF_IFLT_SET: st_next[B_IFLT] = 1'b1;
          OFF_IFLT_CLR: st_next[B_IFLT] = 1'b0;
          OFF_PIR9_SET: st_next[B_PIR9] = 1'b1;
          OFF_PIR9_CLR: st_next[B_PIR9] = 1'b0;
          OFF_PIR8_SET: st_next[B_PIR8] = 1'b1;
          OFF_PIR8_CLR: st_next[B_PIR8] = 1'b0;
          default: ;
        endcase
      end
      MODE_TMR_RD: begin
        // clear-latch read drops the clock bit
        if (req.offset == OFF_TMR_LATCH) st_next[B_CLK] = 1'b0;
      end
      MODE_TICK: begin
        if (cnt1_en && !st[B_ITIM]) st_next[B_CLK] = 1'b1;
      end
      default: ;
    endcase
  end

  assign status_word = st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

endmodule

// ----- sv/csitr_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csitr_counter
// One interval counter: divider, count, mode byte, enable and byte toggle.
// ----------------------------------------------------------------------------
module csitr_counter #(
  parameter bit GATED = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  csitr_pkg::cnt_ctrl_t ctrl,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata,
  output logic                 enabled,
  output logic                 load_pulse
);
  import csitr_pkg::*;

  logic [15:0] divider, divider_next;
  logic [15:0] count, count_next;
  logic [7:0]  mode, mode_next;
  logic        en, en_next;
  logic        tog, tog_next;
  logic [1:0]  bm;

  assign bm = mode[5:4];

  // Next state for this word
  always_comb begin
    divider_next = divider;
    count_next   = count;
    mode_next    = mode;
    en_next      = en;
    tog_next     = tog;
    rdata        = '0;
    load_pulse   = 1'b0;
    if (ctrl.rd) begin
      case (bm)
        BM_LOW:  rdata = count[7:0];
        BM_HIGH: rdata = count[15:8];
        BM_ALT: begin
          rdata    = tog ? count[15:8] : count[7:0];
          tog_next = !tog;
        end
        default: rdata = '0;
      endcase
    end else if (ctrl.wr) begin
      case (bm)
        BM_LOW: begin
          divider_next = {divider[15:8], wdata};
          load_pulse   = 1'b1;
        end
        BM_HIGH: begin
          divider_next = {wdata, divider[7:0]};
          load_pulse   = 1'b1;
        end
        BM_ALT: begin
          // low byte first loads the count but does not start the counter
          if (!tog) begin
            divider_next = {divider[15:8], wdata};
            count_next   = {divider[15:8], wdata};
          end else begin
            divider_next = {wdata, divider[7:0]};
            load_pulse   = 1'b1;
          end
          tog_next = !tog;
        end
        default: ;
      endcase
      if (load_pulse) begin
        count_next = divider_next;
        en_next    = 1'b1;
      end
    end else if (ctrl.ctl) begin
      mode_next = wdata;
      en_next   = 1'b0;
      tog_next  = 1'b0;
    end else if (ctrl.reload && GATED && en) begin
      count_next = divider - 16'd1;
    end
  end

  assign enabled = en;

  // Payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= '0;
      count   <= '0;
      mode    <= '0;
    end else if (adv) begin
      divider <= divider_next;
      count   <= count_next;
      mode    <= mode_next;
    end
  end

  // Control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      en  <= 1'b0;
      tog <= 1'b0;
    end else if (adv) begin
      en  <= en_next;
      tog <= tog_next;
    end
  end

endmodule

// ----- sv/control_status_and_interval_timer_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_status_and_interval_timer_regs
// Control/status word and interval timer register block, one word per cycle while responses drain.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one bus access (status read/write, timer read/write)
//   or a clock tick. Each request word produces exactly one response word on
//   the rsp channel with read data, the status word after the access, a
//   reset request flag and a divider reload pulse.
//   The request is captured in an input register, decoded and applied to
//   the register state in one pass, and the result lands in the response
//   register.
//   Throughput is one word per cycle; the input register and response
//   register are separate stages, so a new request is taken while a response
//   is still waiting, as long as the response register will drain.
//   If the receiver holds rsp_ready low, the response holds, the input
//   register fills, and req_ready drops until the response is taken.
//   Reset clears the status word and all counters; only counter 1 is gated.
// ----------------------------------------------------------------------------
module control_status_and_interval_timer_regs #(
  parameter int NUM_COUNTERS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  csitr_pkg::in_word_t  req_word,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output csitr_pkg::out_word_t rsp_word
);
  import csitr_pkg::*;

  logic      iq_valid;
  in_word_t  iq;
  logic      adv;

  logic [15:0]            st_word;
  logic [15:0]            st_rdata;
  logic                   rst_req;
  logic [MaxCounters-1:0] cnt_en;
  logic [MaxCounters-1:0] cnt_pulse;
  logic [7:0]             cnt_rd [MaxCounters];
  logic [7:0]             cnt_rd_or;
  out_word_t              rsp_next;

  // Handshake: the input stage moves on when the response stage is free
  assign adv       = iq_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !iq_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (req_ready) begin
      iq_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) iq <= req_word;
  end

  // Status word
  csitr_status u_status (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .req           (iq),
    .cnt1_en       (cnt_en[1]),
    .status_word   (st_word),
    .rdata         (st_rdata),
    .reset_request (rst_req)
  );

  // Counters
  for (genvar i = 0; i < MaxCounters; i++) begin : g_cnt
    localparam logic [1:0] IDX = 2'(i);
    if (i < NUM_COUNTERS) begin : g_on
      cnt_ctrl_t ctrl;
      logic      hit;
      assign hit         = (iq.offset == {2'b00, IDX, 2'b11});
      assign ctrl.rd     = (iq.mode == MODE_TMR_RD) && hit;
      assign ctrl.wr     = (iq.mode == MODE_TMR_WR) && hit;
      assign ctrl.ctl    = (iq.mode == MODE_TMR_WR) && (iq.offset == OFF_TMR_CTL) &&
                           (iq.wdata[7:6] == IDX);
      assign ctrl.reload = (iq.mode == MODE_ST_WR) && (iq.offset == OFF_ITIM_CLR);
      csitr_counter #(
        .GATED (i == 1)
      ) u_cnt (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .ctrl       (ctrl),
        .wdata      (iq.wdata),
        .rdata      (cnt_rd[i]),
        .enabled    (cnt_en[i]),
        .load_pulse (cnt_pulse[i])
      );
    end else begin : g_off
      assign cnt_rd[i]    = '0;
      assign cnt_en[i]    = 1'b0;
      assign cnt_pulse[i] = 1'b0;
    end
  end

  // Only the addressed counter drives nonzero read data
  always_comb begin
    cnt_rd_or = '0;
    for (int k = 0; k < MaxCounters; k++) cnt_rd_or = cnt_rd_or | cnt_rd[k];
  end

  // Response assembly
  always_comb begin
    rsp_next.rdata         = (iq.mode == MODE_ST_RD)  ? st_rdata :
                             (iq.mode == MODE_TMR_RD) ? {8'h00, cnt_rd_or} : 16'h0000;
    rsp_next.status_word   = st_word;
    rsp_next.reset_request = (iq.mode == MODE_ST_WR) && rst_req;
    rsp_next.reload_pulse  = (iq.mode == MODE_TMR_WR) && (|cnt_pulse);
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rsp_word <= rsp_next;
  end

endmodule
